// ===== hdl/ihex_pkg.sv =====
// ----------------------------------------------------------------------------
// ihex_pkg
// Types and codes shared by the Intel HEX record parser modules.
// ----------------------------------------------------------------------------
package ihex_pkg;

  localparam logic [1:0] CMD_TEXT    = 2'd0;
  localparam logic [1:0] CMD_RESTART = 2'd1;
  localparam logic [1:0] CMD_END     = 2'd2;
  localparam logic [1:0] CMD_NOP     = 2'd3;

  localparam logic [1:0] KIND_WRITE    = 2'd0;
  localparam logic [1:0] KIND_RECORD   = 2'd1;
  localparam logic [1:0] KIND_COMPLETE = 2'd2;
  localparam logic [1:0] KIND_ERROR    = 2'd3;

  localparam logic [2:0] ERR_NO_COLON  = 3'd0;
  localparam logic [2:0] ERR_BAD_HEX   = 3'd1;
  localparam logic [2:0] ERR_SHORT     = 3'd2;
  localparam logic [2:0] ERR_RANGE     = 3'd3;
  localparam logic [2:0] ERR_CHECKSUM  = 3'd4;
  localparam logic [2:0] ERR_REC_TYPE  = 3'd5;
  localparam logic [2:0] ERR_NO_END    = 3'd6;

  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] REC_DATA     = 8'h00;
  localparam logic [7:0] REC_EOF      = 8'h01;

  typedef enum logic [3:0] {
    PH_COLON, PH_LEN_H, PH_LEN_L, PH_OFF_0, PH_OFF_1, PH_OFF_2, PH_OFF_3,
    PH_TYP_H, PH_TYP_L, PH_DAT_H, PH_DAT_L, PH_CHK_H, PH_CHK_L, PH_EOL
  } phase_t;

  typedef enum logic [1:0] {
    FIN_BUSY,
    FIN_OK,
    FIN_FAIL
  } fin_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] character;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  error_code;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic [15:0] lowest_address;
    logic [15:0] highest_address;
  } out_item_t;

  // classified character
  typedef struct packed {
    logic [1:0] cmd;
    logic       is_colon;
    logic       is_newline;
    logic       is_hex;
    logic [3:0] nibble;
  } tok_t;

endpackage

// ===== hdl/ihex_stream_if.sv =====
// ----------------------------------------------------------------------------
// ihex_stream_if
// Valid/ready stream channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface ihex_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/ihex_front.sv =====
// ----------------------------------------------------------------------------
// ihex_front
// Accepts characters, classifies them and queues the tokens (two entries).
// ----------------------------------------------------------------------------
module ihex_front import ihex_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  ihex_stream_if.sink  chars,
  output tok_t         tok,
  output logic         tok_valid,
  input  logic         tok_pop
);

  tok_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  tok_t       cls;
  logic       take;
  logic       push;

  always_comb begin
    cls.cmd        = chars.data.cmd;
    cls.is_colon   = (chars.data.character == CHAR_COLON);
    cls.is_newline = (chars.data.character == CHAR_NEWLINE);
    cls.is_hex     = 1'b1;
    cls.nibble     = chars.data.character[3:0];
    case (chars.data.character) inside
      [8'h30:8'h39]: cls.nibble = chars.data.character[3:0];
      [8'h41:8'h46],
      [8'h61:8'h66]: cls.nibble = chars.data.character[3:0] + 4'd9;
      default:       cls.is_hex = 1'b0;
    endcase
  end

  assign chars.ready = (count != 2'd2);
  assign take        = chars.valid && chars.ready;
  // no-op commands are taken and dropped
  assign push        = take && (chars.data.cmd != CMD_NOP);
  assign tok_valid   = (count != 2'd0);
  assign tok         = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (tok_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, tok_pop};
    end
  end

endmodule

// ===== hdl/ihex_back.sv =====
// ----------------------------------------------------------------------------
// ihex_back
// Record parser state machine and result register.
// ----------------------------------------------------------------------------
module ihex_back import ihex_pkg::*; #(
  parameter int FLASH_BYTES = 65536
) (
  input  logic          clk,
  input  logic          rst,
  input  tok_t          tok,
  input  logic          tok_valid,
  output logic          tok_pop,
  ihex_stream_if.source results
);

  localparam logic [16:0] FLASH_LIMIT = 17'(FLASH_BYTES);

  phase_t      phase, phase_next;
  fin_t        fin, fin_next;
  logic [3:0]  high_nibble, high_nibble_next;
  logic [7:0]  rec_len, rec_len_next;
  logic [15:0] rec_off, rec_off_next;
  logic [7:0]  bytes_done, bytes_done_next;
  logic [7:0]  sum, sum_next;
  logic [15:0] lowest, lowest_next;
  logic [15:0] highest, highest_next;

  logic        out_valid;
  out_item_t   out_data;
  logic        emit;
  out_item_t   res;

  logic [7:0]  byte_val;
  logic [7:0]  sum_plus;
  logic [15:0] off_shift;
  logic [16:0] addr;
  logic [7:0]  bytes_inc;

  assign tok_pop       = tok_valid && (!out_valid || results.ready);
  assign results.valid = out_valid;
  assign results.data  = out_data;

  assign byte_val  = {high_nibble, tok.nibble};
  assign sum_plus  = sum + byte_val;
  assign off_shift = {rec_off[11:0], tok.nibble};
  assign addr      = {1'b0, rec_off} + {9'd0, bytes_done};
  assign bytes_inc = bytes_done + 8'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_COLON;
      fin         <= FIN_BUSY;
      high_nibble <= '0;
      rec_len     <= '0;
      rec_off     <= '0;
      bytes_done  <= '0;
      sum         <= '0;
      lowest      <= 16'hFFFF;
      highest     <= '0;
    end else if (tok_pop) begin
      phase       <= phase_next;
      fin         <= fin_next;
      high_nibble <= high_nibble_next;
      rec_len     <= rec_len_next;
      rec_off     <= rec_off_next;
      bytes_done  <= bytes_done_next;
      sum         <= sum_next;
      lowest      <= lowest_next;
      highest     <= highest_next;
    end
  end

  always_comb begin
    phase_next       = phase;
    fin_next         = fin;
    high_nibble_next = high_nibble;
    rec_len_next     = rec_len;
    rec_off_next     = rec_off;
    bytes_done_next  = bytes_done;
    sum_next         = sum;
    lowest_next      = lowest;
    highest_next     = highest;
    emit             = 1'b0;
    res              = '0;

    if (tok.cmd == CMD_RESTART) begin
      phase_next       = PH_COLON;
      fin_next         = FIN_BUSY;
      high_nibble_next = '0;
      rec_len_next     = '0;
      rec_off_next     = '0;
      bytes_done_next  = '0;
      sum_next         = '0;
      lowest_next      = 16'hFFFF;
      highest_next     = '0;
    end else if (fin != FIN_BUSY) begin
      phase_next = phase;
    end else if (tok.cmd == CMD_END) begin
      fin_next       = FIN_FAIL;
      emit           = 1'b1;
      res.kind       = KIND_ERROR;
      res.error_code = ERR_NO_END;
    end else if (phase == PH_COLON) begin
      if (!tok.is_colon) begin
        fin_next       = FIN_FAIL;
        emit           = 1'b1;
        res.kind       = KIND_ERROR;
        res.error_code = ERR_NO_COLON;
      end else begin
        sum_next        = '0;
        bytes_done_next = '0;
        rec_off_next    = '0;
        phase_next      = PH_LEN_H;
      end
    end else if (phase == PH_EOL) begin
      if (tok.is_newline) begin
        phase_next = PH_COLON;
      end
    end else if (tok.is_newline) begin
      fin_next       = FIN_FAIL;
      emit           = 1'b1;
      res.kind       = KIND_ERROR;
      res.error_code = ERR_SHORT;
    end else if (!tok.is_hex) begin
      fin_next       = FIN_FAIL;
      emit           = 1'b1;
      res.kind       = KIND_ERROR;
      res.error_code = ERR_BAD_HEX;
    end else begin
      case (phase)
        PH_OFF_0: begin
          rec_off_next = off_shift;
          phase_next   = PH_OFF_1;
        end
        PH_OFF_1: begin
          rec_off_next = off_shift;
          sum_next     = sum + off_shift[7:0];
          phase_next   = PH_OFF_2;
        end
        PH_OFF_2: begin
          rec_off_next = off_shift;
          phase_next   = PH_OFF_3;
        end
        PH_OFF_3: begin
          rec_off_next = off_shift;
          sum_next     = sum + off_shift[7:0];
          phase_next   = PH_TYP_H;
        end
        PH_LEN_H: begin
          high_nibble_next = tok.nibble;
          phase_next       = PH_LEN_L;
        end
        PH_TYP_H: begin
          high_nibble_next = tok.nibble;
          phase_next       = PH_TYP_L;
        end
        PH_DAT_H: begin
          high_nibble_next = tok.nibble;
          phase_next       = PH_DAT_L;
        end
        PH_CHK_H: begin
          high_nibble_next = tok.nibble;
          phase_next       = PH_CHK_L;
        end
        PH_LEN_L: begin
          rec_len_next = byte_val;
          sum_next     = sum_plus;
          phase_next   = PH_OFF_0;
        end
        PH_TYP_L: begin
          sum_next = sum_plus;
          if (byte_val == REC_EOF) begin
            fin_next            = FIN_OK;
            emit                = 1'b1;
            res.kind            = KIND_COMPLETE;
            res.lowest_address  = lowest;
            res.highest_address = highest;
          end else if (byte_val != REC_DATA) begin
            fin_next       = FIN_FAIL;
            emit           = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_REC_TYPE;
          end else begin
            phase_next = (rec_len == 8'd0) ? PH_CHK_H : PH_DAT_H;
          end
        end
        PH_DAT_L: begin
          sum_next = sum_plus;
          if (addr >= FLASH_LIMIT) begin
            fin_next       = FIN_FAIL;
            emit           = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_RANGE;
          end else begin
            if (addr[15:0] < lowest) begin
              lowest_next = addr[15:0];
            end
            if (addr[15:0] > highest) begin
              highest_next = addr[15:0];
            end
            bytes_done_next   = bytes_inc;
            phase_next        = (bytes_inc >= rec_len) ? PH_CHK_H : PH_DAT_H;
            emit              = 1'b1;
            res.kind          = KIND_WRITE;
            res.write_address = addr[15:0];
            res.write_data    = byte_val;
          end
        end
        PH_CHK_L: begin
          sum_next = sum_plus;
          if (sum_plus != 8'd0) begin
            fin_next       = FIN_FAIL;
            emit           = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_CHECKSUM;
          end else begin
            phase_next = PH_EOL;
            emit       = 1'b1;
            res.kind   = KIND_RECORD;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (tok_pop && emit) begin
      out_data <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tok_pop && emit) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_err_code_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.kind != KIND_ERROR) |-> (out_data.error_code == ERR_NO_COLON))
    else $error("error code set on a non-error result");

  a_fin_sticky: assert property (@(posedge clk) disable iff (rst)
    (fin != FIN_BUSY && !(tok_pop && tok.cmd == CMD_RESTART)) |=> (fin == $past(fin)))
    else $error("finished state changed without restart");

  a_bounds_track: assert property (@(posedge clk) disable iff (rst)
    (tok_pop && emit && res.kind == KIND_WRITE) |=>
      (lowest <= $past(res.write_address) && highest >= $past(res.write_address)))
    else $error("address bounds miss a written byte");

  a_no_emit_when_done: assert property (@(posedge clk) disable iff (rst)
    (tok_pop && fin != FIN_BUSY) |-> !emit)
    else $error("result after parse finished");
`endif

endmodule

// ===== hdl/intel_hex_record_parser.sv =====
// ----------------------------------------------------------------------------
// intel_hex_record_parser
// Intel HEX text parser emitting byte writes, record status, bounds and errors.
//
//   channel   dir  transaction payload
//   chars     in   cmd, character
//   results   out  kind, error_code, write_address, write_data,
//                  lowest_address, highest_address
//
// One character per cycle sustained while results are taken. A character
// is queued as a token, then parsed into the result register and offered.
// While a result waits at the output the parser holds; the two-entry token
// queue takes up to two more characters before chars.ready drops.
// Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
module intel_hex_record_parser import ihex_pkg::*; #(
  parameter int FLASH_BYTES = 65536
) (
  input  logic          clk,
  input  logic          rst,
  ihex_stream_if.sink   chars,
  ihex_stream_if.source results
);

  tok_t tok;
  logic tok_valid;
  logic tok_pop;

  ihex_front u_front (
    .clk       (clk),
    .rst       (rst),
    .chars     (chars),
    .tok       (tok),
    .tok_valid (tok_valid),
    .tok_pop   (tok_pop)
  );

  ihex_back #(
    .FLASH_BYTES (FLASH_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .tok       (tok),
    .tok_valid (tok_valid),
    .tok_pop   (tok_pop),
    .results   (results)
  );

endmodule

// ===== tb/intel_hex_record_parser_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// intel_hex_record_parser_tb
// Streams Intel HEX text into the parser: a directed pass over every error
// and end condition, then randomized images of well-formed records with
// occasional corruption and raw noise. A scoreboard predicts each write,
// record status, completion bound and error, and checks every result
// transaction in order. Both handshakes idle at random, and the result side
// holds off once for a long stretch.
// ----------------------------------------------------------------------------
module intel_hex_record_parser_tb;
  import ihex_pkg::*;

  localparam int          FLASH_BYTES = 65536;
  localparam int          RANDOM_ITEMS = 1200;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int          LONG_HOLD_CYCLES = 400;

  typedef enum {
    FAULT_NONE,
    FAULT_CHECKSUM,
    FAULT_BAD_HEX,
    FAULT_SHORT,
    FAULT_NO_COLON
  } fault_t;

  class hex_image_scoreboard;
    phase_t      phase;
    fin_t        status;
    logic [3:0]  hi_nibble;
    logic [7:0]  rec_len;
    logic [15:0] rec_offset;
    logic [7:0]  bytes_taken;
    logic [7:0]  line_sum;
    logic [15:0] lowest;
    logic [15:0] highest;
    out_item_t   pending_results[$];
    int          flash_size;
    int          errors;

    function new(int flash);
      flash_size = flash;
      errors = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      phase = PH_COLON;
      status = FIN_BUSY;
      hi_nibble = '0;
      rec_len = '0;
      rec_offset = '0;
      bytes_taken = '0;
      line_sum = '0;
      lowest = '1;
      highest = '0;
    endfunction

    function bit decode_hex(input logic [7:0] c, output logic [3:0] nib);
      nib = '0;
      if (c >= "0" && c <= "9") nib = 4'(c - "0");
      else if (c >= "A" && c <= "F") nib = 4'(c - "A" + 8'd10);
      else if (c >= "a" && c <= "f") nib = 4'(c - "a" + 8'd10);
      else return 1'b0;
      return 1'b1;
    endfunction

    function void expect_result(logic [1:0] kind, logic [2:0] code, logic [15:0] addr,
                                logic [7:0] data, logic [15:0] lo, logic [15:0] hi);
      out_item_t r;
      r.kind = kind;
      r.error_code = code;
      r.write_address = addr;
      r.write_data = data;
      r.lowest_address = lo;
      r.highest_address = hi;
      pending_results.insert(pending_results.size(), r);
    endfunction

    function void expect_error(logic [2:0] code);
      status = FIN_FAIL;
      expect_result(KIND_ERROR, code, '0, '0, '0, '0);
    endfunction

    function void note_char(in_item_t it);
      logic [3:0]  nib;
      logic [7:0]  value;
      logic [16:0] addr;
      if (it.cmd == CMD_RESTART) begin
        clear_parse();
        return;
      end
      if (it.cmd == CMD_NOP || status != FIN_BUSY) return;
      if (it.cmd == CMD_END) begin
        expect_error(ERR_NO_END);
        return;
      end
      if (phase == PH_COLON) begin
        if (it.character != CHAR_COLON) begin
          expect_error(ERR_NO_COLON);
        end else begin
          line_sum = '0;
          bytes_taken = '0;
          rec_offset = '0;
          phase = PH_LEN_H;
        end
        return;
      end
      if (phase == PH_EOL) begin
        if (it.character == CHAR_NEWLINE) phase = PH_COLON;
        return;
      end
      if (it.character == CHAR_NEWLINE) begin
        expect_error(ERR_SHORT);
        return;
      end
      if (!decode_hex(it.character, nib)) begin
        expect_error(ERR_BAD_HEX);
        return;
      end
      case (phase)
        PH_OFF_0, PH_OFF_1, PH_OFF_2, PH_OFF_3: begin
          rec_offset = {rec_offset[11:0], nib};
          if (phase == PH_OFF_1 || phase == PH_OFF_3) line_sum += rec_offset[7:0];
          phase = phase_t'(phase + 1);
        end
        PH_LEN_H, PH_TYP_H, PH_DAT_H, PH_CHK_H: begin
          hi_nibble = nib;
          phase = phase_t'(phase + 1);
        end
        default: begin
          value = {hi_nibble, nib};
          line_sum += value;
          case (phase)
            PH_LEN_L: begin
              rec_len = value;
              phase = PH_OFF_0;
            end
            PH_TYP_L: begin
              if (value == REC_EOF) begin
                status = FIN_OK;
                expect_result(KIND_COMPLETE, '0, '0, '0, lowest, highest);
              end else if (value != REC_DATA) begin
                expect_error(ERR_REC_TYPE);
              end else begin
                phase = (rec_len == 8'd0) ? PH_CHK_H : PH_DAT_H;
              end
            end
            PH_DAT_L: begin
              addr = {1'b0, rec_offset} + {9'd0, bytes_taken};
              if (addr >= flash_size) begin
                expect_error(ERR_RANGE);
              end else begin
                if (addr[15:0] < lowest) lowest = addr[15:0];
                if (addr[15:0] > highest) highest = addr[15:0];
                bytes_taken++;
                phase = (bytes_taken >= rec_len) ? PH_CHK_H : PH_DAT_H;
                expect_result(KIND_WRITE, '0, addr[15:0], value, '0, '0);
              end
            end
            default: begin
              // checksum low nibble closes the record
              if (line_sum != 8'd0) begin
                expect_error(ERR_CHECKSUM);
              end else begin
                phase = PH_EOL;
                expect_result(KIND_RECORD, '0, '0, '0, '0, '0);
              end
            end
          endcase
        end
      endcase
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual kind %0d code %0d",
                 $time, got.kind, got.error_code);
        return;
      end
      want = pending_results.pop_front();
      compare_field("kind", 32'(want.kind), 32'(got.kind));
      compare_field("error_code", 32'(want.error_code), 32'(got.error_code));
      compare_field("write_address", 32'(want.write_address), 32'(got.write_address));
      compare_field("write_data", 32'(want.write_data), 32'(got.write_data));
      compare_field("lowest_address", 32'(want.lowest_address),
                    32'(got.lowest_address));
      compare_field("highest_address", 32'(want.highest_address),
                    32'(got.highest_address));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  ihex_stream_if #(.T(in_item_t))  chars ();
  ihex_stream_if #(.T(out_item_t)) results ();

  intel_hex_record_parser #(.FLASH_BYTES(FLASH_BYTES)) i_dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars),
    .results (results)
  );

  hex_image_scoreboard sb;
  int          burst_left = 0;
  int          items_sent = 0;
  int          chars_accepted = 0;
  int unsigned cycles = 0;

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && chars.valid && chars.ready) begin
      sb.note_char(chars.data);
      chars_accepted++;
    end
  end

  always @(posedge clk) begin
    if (!rst && results.valid && results.ready) sb.check_result(results.data);
  end

  // result side: stall pattern of its own, plus one long hold-off
  initial begin
    int  mode_left;
    int  stall_pct;
    bit  held;
    mode_left = 0;
    stall_pct = 0;
    held = 1'b0;
    results.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && chars_accepted >= 400) begin
        held = 1'b1;
        results.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(10, 80);
        case ($urandom_range(0, 4))
          0, 1: stall_pct = 0;
          2: stall_pct = 25;
          3: stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      mode_left--;
      results.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic send_item(input logic [1:0] cmd, input logic [7:0] ch);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        chars.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    chars.valid <= 1'b1;
    chars.data <= in_item_t'{cmd, ch};
    do @(posedge clk); while (!chars.ready);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_text(input logic [7:0] ch);
    send_item(CMD_TEXT, ch);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit lower);
    if (nib < 4'd10) return "0" + {4'd0, nib};
    return 8'((lower ? "a" : "A") + {4'd0, nib} - 8'd10);
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    logic [3:0] nib;
    do c = 8'($urandom_range(0, 255));
    while (sb.decode_hex(c, nib) || c == CHAR_NEWLINE);
    return c;
  endfunction

  task automatic send_record(input logic [7:0] len, input logic [15:0] off,
                             input logic [7:0] rtype, input fault_t fault);
    logic [7:0] bytes_q[$];
    logic [7:0] sum;
    logic [7:0] c;
    logic [3:0] nib;
    int         cut;
    bytes_q = {len, off[15:8], off[7:0], rtype};
    repeat (len) bytes_q.insert(bytes_q.size(), 8'($urandom_range(0, 255)));
    sum = '0;
    foreach (bytes_q[i]) sum += bytes_q[i];
    if (fault == FAULT_CHECKSUM)
      bytes_q.insert(bytes_q.size(), (8'h00 - sum) ^ 8'($urandom_range(1, 255)));
    else bytes_q.insert(bytes_q.size(), 8'h00 - sum);
    if (fault == FAULT_NO_COLON) begin
      do c = 8'($urandom_range(0, 255)); while (c == CHAR_COLON);
      send_text($urandom_range(0, 1) ? CHAR_NEWLINE : c);
      return;
    end
    cut = (fault == FAULT_BAD_HEX || fault == FAULT_SHORT)
          ? $urandom_range(0, 2 * bytes_q.size() - 1) : -1;
    send_text(CHAR_COLON);
    for (int k = 0; k < 2 * bytes_q.size(); k++) begin
      if (k == cut) begin
        send_text(fault == FAULT_SHORT ? CHAR_NEWLINE : non_hex_char());
        return;
      end
      nib = k[0] ? bytes_q[k / 2][3:0] : bytes_q[k / 2][7:4];
      send_text(hex_char(nib, 1'($urandom_range(0, 1))));
    end
    if ($urandom_range(0, 3) == 0) send_text(8'h0D);
    if ($urandom_range(0, 9) == 0) begin
      do c = 8'($urandom_range(0, 255)); while (c == CHAR_NEWLINE);
      send_text(c);
    end
    send_text(CHAR_NEWLINE);
  endtask

  task automatic send_image();
    int          n_rec;
    int          pick;
    fault_t      fault;
    logic [7:0]  len;
    logic [15:0] off;
    logic [7:0]  rtype;
    send_item(CMD_RESTART, 8'($urandom_range(0, 255)));
    n_rec = $urandom_range(0, 4);
    for (int r = 0; r < n_rec; r++) begin
      pick = $urandom_range(0, 99);
      len = (pick < 70) ? 8'($urandom_range(0, 8))
          : (pick < 98) ? 8'($urandom_range(9, 32)) : 8'($urandom_range(33, 255));
      off = ($urandom_range(0, 9) == 0) ? 16'(32'hFFFF - $urandom_range(0, 24))
                                        : 16'($urandom_range(0, 65535));
      rtype = REC_DATA;
      fault = FAULT_NONE;
      pick = $urandom_range(0, 99);
      if (pick < 3) fault = FAULT_CHECKSUM;
      else if (pick < 5) fault = FAULT_BAD_HEX;
      else if (pick < 7) fault = FAULT_SHORT;
      else if (pick < 9) fault = FAULT_NO_COLON;
      else if (pick < 11) rtype = 8'($urandom_range(2, 255));
      send_record(len, off, rtype, fault);
      if (fault != FAULT_NONE || rtype != REC_DATA) return;
    end
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      send_item(CMD_END, 8'($urandom_range(0, 255)));
      return;
    end
    send_record(8'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)), REC_EOF,
                FAULT_NONE);
    if (pick < 4) repeat ($urandom_range(1, 4)) send_text(8'($urandom_range(0, 255)));
    if (pick < 7) send_item(CMD_END, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    sb = new(FLASH_BYTES);
    rst = 1'b1;
    chars.valid = 1'b0;
    chars.data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // end of input before any record, then end again once failed
    send_item(CMD_NOP, 8'hFF);
    send_item(CMD_END, 8'h00);
    send_item(CMD_END, 8'hFF);
    send_item(CMD_RESTART, 8'h00);
    send_text(8'hFF);
    send_item(CMD_RESTART, 8'hFF);
    send_text(CHAR_COLON);
    send_text("0");
    send_text(8'h00);
    send_item(CMD_RESTART, 8'h55);
    send_text(CHAR_COLON);
    send_text("0");
    send_text(CHAR_NEWLINE);
    send_item(CMD_RESTART, 8'hAA);
    send_record(8'd2, 16'hFFFF, REC_DATA, FAULT_NONE);
    send_item(CMD_RESTART, 8'h00);
    send_record(8'd0, 16'h0000, 8'h02, FAULT_NONE);
    send_item(CMD_RESTART, 8'h00);
    send_record(8'd1, 16'h1234, REC_DATA, FAULT_CHECKSUM);
    send_item(CMD_RESTART, 8'h00);
    send_record(8'd0, 16'h0000, REC_EOF, FAULT_NONE);
    send_item(CMD_RESTART, 8'h00);
    send_record(8'd3, 16'h0000, REC_DATA, FAULT_NONE);
    send_record(8'd1, 16'hFFFF, REC_DATA, FAULT_NONE);
    send_record(8'd0, 16'h0000, REC_EOF, FAULT_NONE);
    send_text(CHAR_COLON);
    send_item(CMD_END, 8'h00);

    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 85) begin
        send_image();
      end else begin
        repeat ($urandom_range(1, 12))
          send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
    end
    chars.valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
